FILE: sv/pud_pkg.sv
// pud_pkg: shared types, constants and the character value function for the
// percent URL decoder. No dependencies.
`timescale 1ns / 1ps
package pud_pkg;

	localparam int ByteW  = 8;
	localparam int DigitW = 6;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_HIGH = 2'd1;
	localparam logic [1:0] PH_LOW  = 2'd2;

	localparam logic [ByteW-1:0] CH_PLUS    = 8'h2B;
	localparam logic [ByteW-1:0] CH_PERCENT = 8'h25;
	localparam logic [ByteW-1:0] CH_SPACE   = 8'h20;

	typedef struct packed {
		logic [ByteW-1:0] data;
		logic             last;
	} in_beat_t;

	typedef struct packed {
		logic             emit;
		logic [ByteW-1:0] out_byte;
		logic             has_byte;
		logic             out_last;
		logic             truncated;
	} result_t;

	// Digits give 0-9, letters of either case give 10-35, anything else 0.
	function automatic logic [DigitW-1:0] digit_value(input logic [ByteW-1:0] c);
		logic [DigitW-1:0] v;
		v = '0;
		if (c >= 8'h41 && c <= 8'h5A) begin
			v = DigitW'(c - 8'h41 + 8'd10);
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			v = DigitW'(c - 8'h61 + 8'd10);
		end else if (c >= 8'h30 && c <= 8'h39) begin
			v = DigitW'(c - 8'h30);
		end
		return v;
	endfunction

endpackage

FILE: sv/pud_in_stage.sv
// pud_in_stage: input register of the decoder with its stream handshake.
// Depends on pud_pkg.
`timescale 1ns / 1ps
module pud_in_stage import pud_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_valid,
	output logic     s_ready,
	input  in_beat_t s_beat,
	input  logic     advance,
	output logic     valid_s1,
	output in_beat_t beat_s1
);

	// The held beat leaves whenever the next stage takes it, so a new beat can
	// enter in the same cycle.
	assign s_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_ready) begin
			valid_s1 <= s_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_ready && s_valid) begin
			beat_s1 <= s_beat;
		end
	end

endmodule

FILE: sv/pud_decode.sv
// pud_decode: escape state and the per-byte decode logic of the decoder.
// Depends on pud_pkg.
`timescale 1ns / 1ps
module pud_decode import pud_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	input  in_beat_t beat,
	output result_t  res
);

	logic [1:0]        phase_q;
	logic [DigitW-1:0] high_q;
	logic [1:0]        phase_d;
	logic [DigitW-1:0] high_d;
	logic [DigitW-1:0] dval;

	assign dval = digit_value(beat.data);

	always_comb begin
		res     = '0;
		phase_d = PH_IDLE;
		high_d  = '0;
		unique case (phase_q)
			PH_HIGH: begin
				if (beat.last) begin
					res.emit      = 1'b1;
					res.out_last  = 1'b1;
					res.truncated = 1'b1;
				end else begin
					phase_d = PH_LOW;
					high_d  = dval;
				end
			end
			PH_LOW: begin
				res.emit     = 1'b1;
				res.has_byte = 1'b1;
				res.out_last = beat.last;
				res.out_byte = {high_q[3:0], 4'b0000} + {2'b00, dval};
			end
			default: begin
				// Outside an escape; the unused phase code behaves the same.
				if (beat.data == CH_PERCENT) begin
					if (beat.last) begin
						res.emit      = 1'b1;
						res.out_last  = 1'b1;
						res.truncated = 1'b1;
					end else begin
						phase_d = PH_HIGH;
					end
				end else begin
					res.emit     = 1'b1;
					res.has_byte = 1'b1;
					res.out_last = beat.last;
					res.out_byte = (beat.data == CH_PLUS) ? CH_SPACE : beat.data;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			high_q  <= '0;
		end else if (en) begin
			phase_q <= phase_d;
			high_q  <= high_d;
		end
	end

	a_trunc_ends: assert property (@(posedge clk) disable iff (!arst_n)
		res.truncated |-> (res.out_last && !res.has_byte && res.emit))
		else $error("truncated result must end the string without a byte");

	a_no_bad_phase: assert property (@(posedge clk) disable iff (!arst_n)
		en |=> (phase_q != 2'd3))
		else $error("escape phase took the unused code");

	a_open_escape: assert property (@(posedge clk) disable iff (!arst_n)
		(en && phase_q == PH_IDLE && beat.data == CH_PERCENT && !beat.last)
		|=> (phase_q == PH_HIGH))
		else $error("percent sign did not open an escape");

	a_low_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(en && phase_q == PH_LOW) |=> (phase_q == PH_IDLE && high_q == '0))
		else $error("escape did not close after the low digit");

endmodule

FILE: sv/percent_url_decoder.sv
// Path: an accepted beat passes the input register, then is decoded into the
// result register, which presents it on the master side.
// Throughput: one byte per cycle while the master side takes its beats; '%'
// and the high digit of an escape give no output beat, so an escape of three
// bytes yields one beat. Reset: arst_n clears the escape state and both valid
// flags asynchronously; the block is ready for input once reset is released.
`timescale 1ns / 1ps
module percent_url_decoder import pud_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [ByteW-1:0] s_tdata,   // [7:0] in_byte
	input  logic             s_tlast,   // in_last
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [ByteW-1:0] m_tdata,   // [7:0] out_byte
	output logic [1:0]       m_tuser,   // [0] has_byte, [1] truncated
	output logic             m_tlast    // out_last
);

	// The byte first lands in the input register. From there the decode logic
	// reads it together with the escape state and, if the byte produces a
	// result, writes that result into the output register. A byte that only
	// feeds an escape (the percent sign or the high digit) updates the state
	// and leaves no output beat.

	in_beat_t s_beat;
	in_beat_t beat_s1;
	logic     valid_s1;
	logic     advance;
	result_t  res;

	assign s_beat.data = s_tdata;
	assign s_beat.last = s_tlast;

	// The input stage moves on whenever the output register is empty or is
	// being drained in this cycle, so the two sides run without a bubble.
	assign advance = valid_s1 && (!m_tvalid || m_tready);

	pud_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_valid  (s_tvalid),
		.s_ready  (s_tready),
		.s_beat   (s_beat),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.beat_s1  (beat_s1)
	);

	pud_decode u_dec (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.beat   (beat_s1),
		.res    (res)
	);

	// Output register. It loads only results that really exist; otherwise it
	// empties once the downstream side has taken its beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (!m_tvalid || m_tready) begin
			m_tvalid <= advance && res.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.emit) begin
			m_tdata <= res.out_byte;
			m_tuser <= {res.truncated, res.has_byte};
			m_tlast <= res.out_last;
		end
	end

	// A waiting input beat stays put while the output register is blocked.
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && m_tvalid && !m_tready) |=> valid_s1)
		else $error("input stage dropped a beat under backpressure");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !advance)
		else $error("decode advanced into a blocked output register");

	a_trunc_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[1]) |-> (m_tlast && !m_tuser[0]))
		else $error("truncated beat without end mark");

endmodule

FILE: tb/percent_url_decoder_checker.sv
// percent_url_decoder_checker: watches both stream channels of the percent URL
// decoder, predicts each decoded beat and compares it field by field.
// Depends on pud_pkg for widths, escape phases and character constants.
`timescale 1ns / 1ps
module percent_url_decoder_checker import pud_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic             s_tready,
	input  logic [ByteW-1:0] s_tdata,   // [7:0] in_byte
	input  logic             s_tlast,   // in_last
	input  logic             m_tvalid,
	input  logic             m_tready,
	input  logic [ByteW-1:0] m_tdata,   // [7:0] out_byte
	input  logic [1:0]       m_tuser,   // [0] has_byte, [1] truncated
	input  logic             m_tlast,   // out_last
	output int               error_count,
	output int               open_results
);

	typedef struct {
		logic [ByteW-1:0] text;
		logic             has_byte;
		logic             last;
		logic             truncated;
	} decoded_t;

	decoded_t          decoded_q[$];
	logic [1:0]        esc_phase;
	logic [DigitW-1:0] hi_weight;
	int                errors;

	// Value of one escape character: digits 0-9, letters of either case 10-35.
	function automatic logic [DigitW-1:0] char_weight(input logic [ByteW-1:0] c);
		logic [ByteW-1:0] w;
		w = '0;
		if (c >= "0" && c <= "9") begin
			w = c - "0";
		end else if (c >= "A" && c <= "Z") begin
			w = c - "A" + 8'd10;
		end else if (c >= "a" && c <= "z") begin
			w = c - "a" + 8'd10;
		end
		return w[DigitW-1:0];
	endfunction

	task automatic queue_result(input logic [ByteW-1:0] text, input logic has,
			input logic last, input logic trunc);
		decoded_t d;
		d.text      = text;
		d.has_byte  = has;
		d.last      = last;
		d.truncated = trunc;
		decoded_q.insert(decoded_q.size(), d);
	endtask

	// Advances the escape state by one raw character and queues its beat, if any.
	task automatic decode_char(input logic [ByteW-1:0] c, input logic last);
		logic [ByteW-1:0] value;
		case (esc_phase)
			PH_HIGH: begin
				if (last) begin
					// String ended right after the percent sign.
					esc_phase = PH_IDLE;
					hi_weight = '0;
					queue_result('0, 1'b0, 1'b1, 1'b1);
				end else begin
					hi_weight = char_weight(c);
					esc_phase = PH_LOW;
				end
			end
			PH_LOW: begin
				value     = {hi_weight[3:0], 4'b0000} + ByteW'(char_weight(c));
				esc_phase = PH_IDLE;
				hi_weight = '0;
				queue_result(value, 1'b1, last, 1'b0);
			end
			default: begin
				esc_phase = PH_IDLE;
				if (c == CH_PERCENT) begin
					if (last) begin
						queue_result('0, 1'b0, 1'b1, 1'b1);
					end else begin
						esc_phase = PH_HIGH;
					end
				end else if (c == CH_PLUS) begin
					queue_result(CH_SPACE, 1'b1, last, 1'b0);
				end else begin
					queue_result(c, 1'b1, last, 1'b0);
				end
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		decoded_t exp_beat;
		if (!arst_n) begin
			esc_phase = PH_IDLE;
			hi_weight = '0;
			decoded_q.delete();
		end else begin
			if (s_tvalid && s_tready) begin
				decode_char(s_tdata, s_tlast);
			end
			if (m_tvalid && m_tready) begin
				if (decoded_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected beat byte=%02h has=%0b last=%0b trunc=%0b",
						$realtime, m_tdata, m_tuser[0], m_tlast, m_tuser[1]);
				end else begin
					exp_beat = decoded_q.pop_front();
					if (m_tdata !== exp_beat.text || m_tuser[0] !== exp_beat.has_byte ||
							m_tlast !== exp_beat.last || m_tuser[1] !== exp_beat.truncated) begin
						errors++;
						$display("%0t: mismatch expected byte=%02h has=%0b last=%0b trunc=%0b",
							$realtime, exp_beat.text, exp_beat.has_byte, exp_beat.last,
							exp_beat.truncated);
						$display("%0t:          actual   byte=%02h has=%0b last=%0b trunc=%0b",
							$realtime, m_tdata, m_tuser[0], m_tlast, m_tuser[1]);
					end
				end
			end
		end
		error_count  <= errors;
		open_results <= decoded_q.size();
	end

endmodule

FILE: tb/percent_url_decoder_tb.sv
// percent_url_decoder_tb: drives encoded URL strings into the decoder with
// random idling on both sides and gives the verdict.
// Depends on pud_pkg, percent_url_decoder and percent_url_decoder_checker.
`timescale 1ns / 1ps
module percent_url_decoder_tb;
	import pud_pkg::*;

	// Cycles without any accepted beat, on either side, before we give up.
	localparam int StallLimit = 2000;
	// Random input beats to send after the directed part.
	localparam int RandomChars = 450;
	// Cycles to linger once nothing is expected, to catch stray output beats.
	localparam int DrainCycles = 8;

	logic             clk      = 1'b0;
	logic             arst_n   = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [ByteW-1:0] s_tdata  = '0;    // [7:0] in_byte
	logic             s_tlast  = 1'b0;  // in_last
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [ByteW-1:0] m_tdata;          // [7:0] out_byte
	logic [1:0]       m_tuser;          // [0] has_byte, [1] truncated
	logic             m_tlast;          // out_last

	int error_count;
	int open_results;
	int send_idle_pct = 6;
	int recv_idle_pct = 86;
	int chars_sent    = 0;
	int stall_cycles  = 0;

	always #5 clk = ~clk;

	percent_url_decoder u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	percent_url_decoder_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tlast      (s_tlast),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.m_tlast      (m_tlast),
		.error_count  (error_count),
		.open_results (open_results)
	);

	// The receiver drops ready at random, one fresh decision per cycle.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Any accepted beat, input or output, counts as progress. A run whose
	// stall count reaches StallLimit is a hang and fails.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= StallLimit) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// Offers one raw character and returns at the edge where it is taken.
	// Valid stays high on return so that back-to-back beats have no bubble;
	// an idle gap, when drawn, is the only thing in this task that lowers it.
	task automatic push_char(input logic [ByteW-1:0] c, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= last;
		do begin
			@(posedge clk);
		end while (!s_tready);
		chars_sent++;
	endtask

	// A character for inside an escape: mostly digits and letters, sometimes
	// an arbitrary byte; a non-alphanumeric one decodes as a zero digit.
	function automatic logic [ByteW-1:0] escape_char();
		logic [ByteW-1:0] c;
		case ($urandom_range(3))
			0: c = "0" + ByteW'($urandom_range(9));
			1: c = "A" + ByteW'($urandom_range(25));
			2: c = "a" + ByteW'($urandom_range(25));
			default: c = ByteW'($urandom_range(255));
		endcase
		return c;
	endfunction

	// Builds one encoded string from escapes, plus signs, stray percent signs
	// and raw bytes, optionally cut off inside a final escape, and sends it.
	// A few strings carry no last mark so the escape state runs across them.
	task automatic send_string();
		logic [ByteW-1:0] text_q[$];
		int               units;
		int               pick;
		bit               open_end;
		units = $urandom_range(1, 10);
		for (int u = 0; u < units; u++) begin
			pick = $urandom_range(99);
			if (pick < 30) begin
				text_q.insert(text_q.size(), CH_PERCENT);
				text_q.insert(text_q.size(), escape_char());
				text_q.insert(text_q.size(), escape_char());
			end else if (pick < 42) begin
				text_q.insert(text_q.size(), CH_PLUS);
			end else if (pick < 47) begin
				text_q.insert(text_q.size(), CH_PERCENT);
			end else begin
				text_q.insert(text_q.size(), ByteW'($urandom_range(255)));
			end
		end
		if ($urandom_range(99) < 15) begin
			text_q.insert(text_q.size(), CH_PERCENT);
			if ($urandom_range(1) == 1) begin
				text_q.insert(text_q.size(), escape_char());
			end
		end
		open_end = ($urandom_range(99) < 8);
		foreach (text_q[i]) begin
			push_char(text_q[i], !open_end && (i == text_q.size() - 1));
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed strings: plain and extreme bytes, plus sign, ordinary and
		// overflowing escapes, a non-digit inside an escape, and strings that
		// end on the percent sign, on the high digit and on the low digit.
		push_char("a", 1'b0);
		push_char(CH_PLUS, 1'b0);
		push_char(CH_PERCENT, 1'b0);
		push_char("4", 1'b0);
		push_char("1", 1'b0);
		push_char(CH_PERCENT, 1'b0);
		push_char("z", 1'b0);
		push_char("Z", 1'b0);
		push_char(CH_PERCENT, 1'b0);
		push_char("-", 1'b0);
		push_char("7", 1'b0);
		push_char(8'h00, 1'b0);
		push_char(8'hFF, 1'b1);
		push_char(CH_PERCENT, 1'b1);
		push_char(CH_PERCENT, 1'b0);
		push_char("F", 1'b1);
		push_char(CH_PERCENT, 1'b0);
		push_char("a", 1'b0);
		push_char("F", 1'b1);
		push_char("x", 1'b1);

		// Random strings in three stretches: a mostly stalled receiver, then
		// a mostly idle sender, then both sides at full rate.
		for (int stretch = 0; stretch < 3; stretch++) begin
			case (stretch)
				0: begin
					send_idle_pct = 6;
					recv_idle_pct = 86;
				end
				1: begin
					send_idle_pct = 86;
					recv_idle_pct = 6;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			while (chars_sent < 20 + (stretch + 1) * RandomChars / 3) begin
				send_string();
			end
		end
		s_tvalid <= 1'b0;

		// The pending count is registered, so wait for an edge before reading it.
		@(posedge clk);
		while (open_results != 0) begin
			@(posedge clk);
		end
		repeat (DrainCycles) @(posedge clk);

		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
